>>> rtl/mfq_pkg.sv
// ----------------------------------------------------------------------------
// MFQ scheduler package
// Shared types and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

	// Level numbers are carried at the widest supported level count (16).
	localparam int LV_W = 4;
	typedef logic [LV_W-1:0] lvl_t;

	// Opcodes of an input item.
	localparam logic OP_ADMIT     = 1'b0;
	localparam logic OP_SLICE_END = 1'b1;

	// Configuration register indexes.
	localparam logic REG_BASE_QUANTUM  = 1'b0;
	localparam logic REG_ACTIVE_LEVELS = 1'b1;

	localparam logic [15:0] BASE_QUANTUM_RST  = 16'd100;
	localparam logic [3:0]  ACTIVE_LEVELS_RST = 4'd5;
	localparam logic [19:0] SLICE_MAX         = 20'hFFFFF;

	// Push and pop requests to the pointer file.
	typedef struct packed {
		logic push;
		lvl_t push_lv;
		logic pop;
		lvl_t pop_lv;
	} ptr_req_t;

	// Result of the priority search over the levels.
	typedef struct packed {
		logic found;
		lvl_t lv;
	} ptr_stat_t;

endpackage

>>> rtl/mfq_ram.sv
// ----------------------------------------------------------------------------
// MFQ generic RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mfq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// The read register holds its value while no read is issued.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/mfq_queue_ptrs.sv
// ----------------------------------------------------------------------------
// MFQ queue pointer file
// Head, tail and fill count of every level, plus the search for the
// highest-priority nonempty active level.
// ----------------------------------------------------------------------------
module mfq_queue_ptrs #(
	parameter int LEVELS      = 8,
	parameter int LEVEL_DEPTH = 64,
	parameter int LW          = 3,
	parameter int IW          = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mfq_pkg::ptr_req_t   req,
	input  logic [mfq_pkg::LV_W:0] nlev,
	output logic                push_full,
	output logic [IW-1:0]       push_idx,
	output mfq_pkg::ptr_stat_t  stat,
	output logic [IW-1:0]       pop_idx
);

	import mfq_pkg::*;

	localparam int CW = $clog2(LEVEL_DEPTH + 1);

	logic [IW-1:0] head_q  [LEVELS];
	logic [IW-1:0] tail_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	logic [LW-1:0] push_sel;
	logic [LW-1:0] pop_sel;

	assign push_sel  = req.push_lv[LW-1:0];
	assign pop_sel   = req.pop_lv[LW-1:0];
	assign push_full = (count_q[push_sel] >= CW'(LEVEL_DEPTH));
	assign push_idx  = tail_q[push_sel];
	assign pop_idx   = head_q[stat.lv[LW-1:0]];

	// Lowest-numbered active level that holds a task.
	always_comb begin
		stat = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if ((count_q[i] != '0) && ((LV_W + 1)'(i) < nlev)) begin
				stat.found = 1'b1;
				stat.lv    = LV_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				logic do_push;
				logic do_pop;
				do_push = req.push && (push_sel == LW'(i)) && !push_full;
				do_pop  = req.pop && (pop_sel == LW'(i));
				if (do_push) begin
					tail_q[i] <= (tail_q[i] == IW'(LEVEL_DEPTH - 1)) ? '0 : tail_q[i] + 1'b1;
				end
				if (do_pop) begin
					head_q[i] <= (head_q[i] == IW'(LEVEL_DEPTH - 1)) ? '0 : head_q[i] + 1'b1;
				end
				if (do_push && !do_pop) begin
					count_q[i] <= count_q[i] + 1'b1;
				end else if (do_pop && !do_push) begin
					count_q[i] <= count_q[i] - 1'b1;
				end
			end
		end
	end

	logic any_over;
	always_comb begin
		any_over = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (count_q[i] > CW'(LEVEL_DEPTH)) begin
				any_over = 1'b1;
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n) !any_over)
		else $error("level fill count exceeds its depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> (count_q[pop_sel] != '0))
		else $error("pop from an empty level");

	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(req.push && push_full && !req.pop) |=>
		(count_q[$past(push_sel)] == $past(count_q[push_sel])))
		else $error("full level accepted a push");

endmodule

>>> rtl/multilevel_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel feedback queue scheduler
// Task queues live in one RAM; per-level pointers and counts in flip-flops.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes s1_q, then s2_q; done is high while s2_q is set.
// busy is high for the cycle in which the pointer file is searched and the
// queue RAM read is issued; no new item is accepted while busy is high.
// The queue store needs no clearing pass: fill counts guard every read.
// Reset clears all pointers, counts and the running task; the receiver of
// results cannot stall, each result is shown for one cycle on done.
module multilevel_feedback_queue_scheduler #(
	parameter int LEVELS      = 8,
	parameter int LEVEL_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] task_id,
	input  logic        still_running,
	output logic        done,
	output logic        dispatch_valid,
	output logic [15:0] dispatched_task,
	output logic [2:0]  dispatched_level,
	output logic [19:0] slice_length,
	output logic        retired_valid,
	output logic [15:0] retired_task,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	import mfq_pkg::*;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int IW = $clog2(LEVEL_DEPTH);
	localparam int AW = LW + IW;

	logic [15:0]   base_quantum_q;
	logic [3:0]    active_levels_q;
	logic          running_valid_q;
	lvl_t          running_level_q;

	logic          s1_q;
	logic          op_s1;
	logic          st_s1;
	logic          ret_s1;
	logic [15:0]   ret_task_s1;

	logic          s2_q;
	logic          dv_s2;
	logic [2:0]    level_s2;
	logic [19:0]   slice_s2;
	logic          st_s2;
	logic          ret_s2;
	logic [15:0]   ret_task_s2;

	logic          accept;
	logic [LV_W:0] nlev;
	logic [LV_W:0] nlev_m1;
	logic [LV_W:0] run_next;
	lvl_t          target;
	ptr_req_t      req;
	ptr_stat_t     stat;
	logic          push_full;
	logic [IW-1:0] push_idx;
	logic [IW-1:0] pop_idx;
	logic          ram_we;
	logic [15:0]   ram_wdata;
	logic [15:0]   ram_rdata;
	logic [20:0]   slice_full;

	assign accept    = start && !busy;
	assign busy      = s1_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (active_levels_q == '0) begin
			nlev = (LV_W + 1)'(1);
		end else if ({1'b0, active_levels_q} > (LV_W + 1)'(LEVELS)) begin
			nlev = (LV_W + 1)'(LEVELS);
		end else begin
			nlev = {1'b0, active_levels_q};
		end
	end

	assign nlev_m1  = nlev - 1'b1;
	assign run_next = {1'b0, running_level_q} + 1'b1;
	assign target   = (run_next > nlev_m1) ? nlev_m1[LV_W-1:0] : run_next[LV_W-1:0];

	// The RAM read register keeps the running task between dispatches.
	always_comb begin
		req         = '0;
		req.push_lv = target;
		ram_wdata   = ram_rdata;
		if (accept) begin
			unique case (opcode)
				OP_ADMIT: begin
					req.push    = 1'b1;
					req.push_lv = '0;
					ram_wdata   = task_id;
				end
				OP_SLICE_END: begin
					req.push = running_valid_q && still_running;
				end
				default: begin
					req.push = 1'b0;
				end
			endcase
		end
		req.pop    = s1_q && (op_s1 == OP_SLICE_END) && stat.found;
		req.pop_lv = stat.lv;
	end

	assign ram_we     = req.push && !push_full;
	assign slice_full = 21'({stat.lv, 1'b1}) * 21'(base_quantum_q);

	mfq_queue_ptrs #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.LW          (LW),
		.IW          (IW)
	) u_ptrs (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.nlev      (nlev),
		.push_full (push_full),
		.push_idx  (push_idx),
		.stat      (stat),
		.pop_idx   (pop_idx)
	);

	mfq_ram #(
		.WIDTH (16),
		.DEPTH (1 << AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({req.push_lv[LW-1:0], push_idx}),
		.wdata (ram_wdata),
		.re    (req.pop),
		.raddr ({stat.lv[LW-1:0], pop_idx}),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_quantum_q  <= BASE_QUANTUM_RST;
			active_levels_q <= ACTIVE_LEVELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_QUANTUM:  base_quantum_q  <= cfg_data;
				REG_ACTIVE_LEVELS: active_levels_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q            <= 1'b0;
			s2_q            <= 1'b0;
			running_valid_q <= 1'b0;
			running_level_q <= '0;
		end else begin
			s1_q <= accept;
			s2_q <= s1_q;
			if (accept && (opcode == OP_SLICE_END)) begin
				running_valid_q <= 1'b0;
			end else if (req.pop) begin
				running_valid_q <= 1'b1;
				running_level_q <= stat.lv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= opcode;
			st_s1       <= req.push && push_full;
			ret_s1      <= (opcode == OP_SLICE_END) && running_valid_q && !still_running;
			ret_task_s1 <= ram_rdata;
		end
		if (s1_q) begin
			dv_s2       <= req.pop;
			level_s2    <= stat.lv[2:0];
			slice_s2    <= slice_full[20] ? SLICE_MAX : slice_full[19:0];
			st_s2       <= st_s1;
			ret_s2      <= ret_s1;
			ret_task_s2 <= ret_task_s1;
		end
	end

	assign done             = s2_q;
	assign dispatch_valid   = dv_s2;
	assign dispatched_task  = dv_s2 ? ram_rdata : '0;
	assign dispatched_level = dv_s2 ? level_s2 : '0;
	assign slice_length     = dv_s2 ? slice_s2 : '0;
	assign retired_valid    = ret_s2;
	assign retired_task     = ret_s2 ? ret_task_s2 : '0;
	assign status           = st_s2;

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted item produced no result");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s1_q |-> !s2_q)
		else $error("two items in flight");

	a_drop_not_retire: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(status && retired_valid))
		else $error("dropped task also reported as retired");

	a_pop_only_on_slice_end: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> (s1_q && (op_s1 == OP_SLICE_END)))
		else $error("dispatch outside a slice-end item");

endmodule
